// ===== src/xpbd_distance_constraint_solve_macros.svh =====
// assertion macros for the distance constraint solver
// used by the port checker only, no other dependencies
`ifndef XPBD_DISTANCE_CONSTRAINT_SOLVE_MACROS_SVH
`define XPBD_DISTANCE_CONSTRAINT_SOLVE_MACROS_SVH

// same-cycle implication
`define XDC_ASSERT_IMP(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("xdc port check failed");

// next-cycle implication
`define XDC_ASSERT_NXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("xdc port check failed");

`endif

// ===== src/xdc_pkg.sv =====
// shared types, constants and helpers of the distance constraint solver
// no dependencies
`default_nettype none

package xdc_pkg;

  localparam int D_W     = 33;   // exact position difference
  localparam int LEN2_W  = 66;   // squared length, Q32.32
  localparam int ROOT_W  = 34;   // length, Q16.16
  localparam int DEN_W   = 34;   // divider denominators
  localparam int DLREM_W = 66;   // multiplier step dividend
  localparam int DLQ_W   = 33;   // multiplier step quotient bits
  localparam int NREM_W  = 49;   // direction dividend
  localparam int NQ_W    = 17;   // direction quotient bits
  localparam int MAG_W   = 50;   // magnitude fed to saturation

  localparam logic [LEN2_W-1:0] LEN2_EPS = 66'd43;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPLIANCE_ON = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA         = 1'd1;

  // payload carried alongside the arithmetic
  typedef struct packed {
    logic [15:0]        eid;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;
    logic [30:0]        wi;
    logic [30:0]        wj;
    logic [30:0]        rest;
    logic signed [31:0] lam;
    logic               skip;
  } xdc_side_t;

  // payload carried through the divider chain
  typedef struct packed {
    xdc_side_t          side;
    logic [DEN_W-1:0]   len;
    logic [DEN_W-1:0]   den;
    logic               ovf;
    logic               dneg;
  } xdc_dv_t;

  // magnitude of a difference
  function automatic logic [D_W-1:0] mag33(input logic signed [D_W-1:0] v);
    logic [D_W-1:0] r;
    if (v[D_W-1]) r = D_W'(-v);
    else r = D_W'(v);
    return r;
  endfunction

  // sign and magnitude to saturated signed 32 bit
  function automatic logic signed [31:0] sat_mag(input logic neg,
                                                 input logic [MAG_W-1:0] m);
    logic signed [31:0] r;
    if (neg) begin
      if (m > 50'h0_8000_0000) r = 32'sh8000_0000;
      else r = -$signed(m[31:0]);
    end else begin
      if (m > 50'h0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
      else r = $signed(m[31:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/xdc_sqrt_cell.sv =====
// one bit of the restoring square root chain
// depends on xdc_pkg
`default_nettype none

module xdc_sqrt_cell #(
  parameter int BIT = 0
) (
  input  wire logic                       clk,
  input  wire logic                       adv,
  input  wire logic [xdc_pkg::LEN2_W-1:0] rem_i,
  input  wire logic [xdc_pkg::ROOT_W-1:0] root_i,
  output logic      [xdc_pkg::LEN2_W-1:0] rem_o,
  output logic      [xdc_pkg::ROOT_W-1:0] root_o
);
  import xdc_pkg::*;

  localparam int TW = LEN2_W + 2;

  logic [TW-1:0] trial;
  logic [TW-1:0] rem_x;
  logic          take;

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    trial = (TW'(root_i) << (BIT + 1)) | (TW'(1) << (2 * BIT));
    rem_x = TW'(rem_i);
    take  = rem_x >= trial;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        rem_o  <= LEN2_W'(rem_x - trial);
        root_o <= root_i | (ROOT_W'(1) << BIT);
      end else begin
        rem_o  <= rem_i;
        root_o <= root_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/xdc_div_cell.sv =====
// one quotient bit of a restoring divider chain
// no dependencies
`default_nettype none

module xdc_div_cell #(
  parameter int QBIT  = 0,
  parameter int REM_W = 8,
  parameter int DEN_W = 4,
  parameter int Q_W   = 4
) (
  input  wire logic             clk,
  input  wire logic             adv,
  input  wire logic [REM_W-1:0] rem_i,
  input  wire logic [DEN_W-1:0] den_i,
  input  wire logic [Q_W-1:0]   q_i,
  output logic      [REM_W-1:0] rem_o,
  output logic      [Q_W-1:0]   q_o
);

  localparam int CMP_W = (REM_W > DEN_W + QBIT) ? REM_W : DEN_W + QBIT;

  logic [CMP_W-1:0] shifted;
  logic [CMP_W-1:0] rem_x;
  logic             take;

  // compare remainder against the shifted denominator
  always_comb begin
    shifted = CMP_W'(den_i) << QBIT;
    rem_x   = CMP_W'(rem_i);
    take    = rem_x >= shifted;
  end

  // stage registers
  always_ff @(posedge clk) begin
    if (adv) begin
      if (take) begin
        rem_o <= REM_W'(rem_x - shifted);
        q_o   <= q_i | (Q_W'(1) << QBIT);
      end else begin
        rem_o <= rem_i;
        q_o   <= q_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/xpbd_distance_constraint_solve.sv =====
// channel   | handshake          | payload
// ----------+--------------------+-------------------------------------------
// input     | in_valid/in_stall  | edge_id, pos_i_*, pos_j_*, weights, rest,
//           |                    | lambda_in
// output    | out_valid/out_stall| edge_id_out, corr_i_*, corr_j_*,
//           |                    | lambda_out, skipped
// config    | cfg_we             | cfg_idx, cfg_data
//
// one transaction per cycle while the output is not stalled; a result passes
// through the 34-cell square root chain and the 33-cell divider chain.
// all stages advance together; the whole chain holds while the output
// register is full and stalled, so in_stall = out_valid & out_stall.
// rst (synchronous) clears valid bits and both config registers.
// depends on xdc_pkg, xdc_sqrt_cell, xdc_div_cell
`default_nettype none

module xpbd_distance_constraint_solve (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [xdc_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [31:0]                       cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [15:0]                       edge_id,
  input  wire logic signed [31:0]                pos_i_x,
  input  wire logic signed [31:0]                pos_i_y,
  input  wire logic signed [31:0]                pos_i_z,
  input  wire logic signed [31:0]                pos_j_x,
  input  wire logic signed [31:0]                pos_j_y,
  input  wire logic signed [31:0]                pos_j_z,
  input  wire logic [30:0]                       weight_i,
  input  wire logic [30:0]                       weight_j,
  input  wire logic [30:0]                       rest_length,
  input  wire logic signed [31:0]                lambda_in,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [15:0]                            edge_id_out,
  output logic signed [31:0]                     corr_i_x,
  output logic signed [31:0]                     corr_i_y,
  output logic signed [31:0]                     corr_i_z,
  output logic signed [31:0]                     corr_j_x,
  output logic signed [31:0]                     corr_j_y,
  output logic signed [31:0]                     corr_j_z,
  output logic signed [31:0]                     lambda_out,
  output logic                                   skipped
);
  import xdc_pkg::*;

  localparam int SQ_N = ROOT_W;   // square root cells
  localparam int DV_N = DLQ_W;    // divider cells

  logic        adv;
  logic        compliance_on;
  logic [31:0] alpha;

  // global advance
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      compliance_on <= 1'b0;
      alpha         <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_COMPLIANCE_ON: compliance_on <= cfg_data[0];
        CFG_ALPHA:         alpha         <= cfg_data;
        default:           ;
      endcase
    end
  end

  // stage a: differences
  xdc_side_t a_side;
  logic      a_v;

  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (adv) a_v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_side.eid  <= edge_id;
      a_side.dx   <= {pos_i_x[31], pos_i_x} - {pos_j_x[31], pos_j_x};
      a_side.dy   <= {pos_i_y[31], pos_i_y} - {pos_j_y[31], pos_j_y};
      a_side.dz   <= {pos_i_z[31], pos_i_z} - {pos_j_z[31], pos_j_z};
      a_side.wi   <= weight_i;
      a_side.wj   <= weight_j;
      a_side.rest <= rest_length;
      a_side.lam  <= lambda_in;
      a_side.skip <= ({1'b0, weight_i} + {1'b0, weight_j}) == 32'd0;
    end
  end

  // stage b: squares
  xdc_side_t          b_side;
  logic               b_v;
  logic [LEN2_W-1:0]  b_sqx, b_sqy, b_sqz;

  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (adv) b_v <= a_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side <= a_side;
      b_sqx  <= LEN2_W'(mag33(a_side.dx)) * LEN2_W'(mag33(a_side.dx));
      b_sqy  <= LEN2_W'(mag33(a_side.dy)) * LEN2_W'(mag33(a_side.dy));
      b_sqz  <= LEN2_W'(mag33(a_side.dz)) * LEN2_W'(mag33(a_side.dz));
    end
  end

  // square root chain, entry is the squared length
  logic [LEN2_W-1:0] sq_rem  [SQ_N+1];
  logic [ROOT_W-1:0] sq_root [SQ_N+1];
  xdc_side_t         sq_side [SQ_N+1];
  logic              sq_v    [SQ_N+1];
  logic [LEN2_W-1:0] len2;

  assign len2 = b_sqx + b_sqy + b_sqz;

  always_ff @(posedge clk) begin
    if (rst) sq_v[0] <= 1'b0;
    else if (adv) sq_v[0] <= b_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0]       <= len2;
      sq_root[0]      <= '0;
      sq_side[0]      <= b_side;
      sq_side[0].skip <= b_side.skip || (len2 < LEN2_EPS);
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
    xdc_sqrt_cell #(.BIT(SQ_N - 1 - k)) u_cell (
      .clk    (clk),
      .adv    (adv),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );

    always_ff @(posedge clk) begin
      if (rst) sq_v[k+1] <= 1'b0;
      else if (adv) sq_v[k+1] <= sq_v[k];
    end

    always_ff @(posedge clk) begin
      if (adv) sq_side[k+1] <= sq_side[k];
    end
  end

  // stage d: constraint value, alpha*lambda, denominator
  xdc_side_t          d_side;
  logic               d_v;
  logic [ROOT_W-1:0]  d_len;
  logic signed [35:0] d_c;
  logic [63:0]        d_am;
  logic [DEN_W-1:0]   d_den;
  logic [31:0]        alpha_eff;
  logic [31:0]        lam_mag;

  assign alpha_eff = compliance_on ? alpha : 32'd0;
  assign lam_mag   = sq_side[SQ_N].lam[31] ? 32'(-sq_side[SQ_N].lam)
                                           : 32'(sq_side[SQ_N].lam);

  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (adv) d_v <= sq_v[SQ_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_side <= sq_side[SQ_N];
      d_len  <= sq_root[SQ_N];
      d_c    <= $signed({2'b00, sq_root[SQ_N]}) - $signed({5'b00000, sq_side[SQ_N].rest});
      d_am   <= 64'(alpha_eff) * 64'(lam_mag);
      d_den  <= DEN_W'(sq_side[SQ_N].wi) + DEN_W'(sq_side[SQ_N].wj) + DEN_W'(alpha_eff);
    end
  end

  // stage e: numerator c + alpha*lambda
  xdc_side_t          e_side;
  logic               e_v;
  logic [ROOT_W-1:0]  e_len;
  logic [DEN_W-1:0]   e_den;
  logic signed [49:0] e_num;
  logic signed [49:0] amq_s;

  assign amq_s = d_side.lam[31] ? -$signed({2'b00, d_am[63:16]})
                                : $signed({2'b00, d_am[63:16]});

  always_ff @(posedge clk) begin
    if (rst) e_v <= 1'b0;
    else if (adv) e_v <= d_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_side <= d_side;
      e_len  <= d_len;
      e_den  <= d_den;
      e_num  <= {{14{d_c[35]}}, d_c} + amq_s;
    end
  end

  // stage f: magnitude and sign of the negated numerator
  xdc_side_t         f_side;
  logic              f_v;
  logic [ROOT_W-1:0] f_len;
  logic [DEN_W-1:0]  f_den;
  logic [MAG_W-1:0]  f_mag;
  logic              f_dneg;

  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (adv) f_v <= e_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side <= e_side;
      f_len  <= e_len;
      f_den  <= e_den;
      f_mag  <= e_num[49] ? MAG_W'(-e_num) : MAG_W'(e_num);
      f_dneg <= !e_num[49] && (e_num != 50'sd0);
    end
  end

  // divider chain: multiplier step and the three direction components
  xdc_dv_t            dv    [DV_N+1];
  logic               dv_v  [DV_N+1];
  logic [DLREM_W-1:0] dl_rem[DV_N+1];
  logic [DLQ_W-1:0]   dl_q  [DV_N+1];
  logic [NREM_W-1:0]  n_rem [3][NQ_W+1];
  logic [NQ_W-1:0]    n_q   [3][DV_N+1];

  always_ff @(posedge clk) begin
    if (rst) dv_v[0] <= 1'b0;
    else if (adv) dv_v[0] <= f_v;
  end

  // chain entry, overflow when the quotient would reach 2^33
  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].side  <= f_side;
      dv[0].len   <= f_len;
      dv[0].den   <= f_den;
      dv[0].dneg  <= f_dneg;
      dv[0].ovf   <= {1'b0, f_mag} >= {f_den, 17'd0};
      dl_rem[0]   <= {f_mag, 16'd0};
      dl_q[0]     <= '0;
      n_rem[0][0] <= {mag33(f_side.dx), 16'd0};
      n_rem[1][0] <= {mag33(f_side.dy), 16'd0};
      n_rem[2][0] <= {mag33(f_side.dz), 16'd0};
      n_q[0][0]   <= '0;
      n_q[1][0]   <= '0;
      n_q[2][0]   <= '0;
    end
  end

  for (genvar i = 0; i < DV_N; i++) begin : g_div
    xdc_div_cell #(
      .QBIT (DV_N - 1 - i),
      .REM_W(DLREM_W),
      .DEN_W(DEN_W),
      .Q_W  (DLQ_W)
    ) u_dl (
      .clk  (clk),
      .adv  (adv),
      .rem_i(dl_rem[i]),
      .den_i(dv[i].den),
      .q_i  (dl_q[i]),
      .rem_o(dl_rem[i+1]),
      .q_o  (dl_q[i+1])
    );

    for (genvar k = 0; k < 3; k++) begin : g_dir
      if (i < NQ_W) begin : g_cell
        xdc_div_cell #(
          .QBIT (NQ_W - 1 - i),
          .REM_W(NREM_W),
          .DEN_W(DEN_W),
          .Q_W  (NQ_W)
        ) u_n (
          .clk  (clk),
          .adv  (adv),
          .rem_i(n_rem[k][i]),
          .den_i(dv[i].len),
          .q_i  (n_q[k][i]),
          .rem_o(n_rem[k][i+1]),
          .q_o  (n_q[k][i+1])
        );
      end else begin : g_hold
        always_ff @(posedge clk) begin
          if (adv) n_q[k][i+1] <= n_q[k][i];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) dv_v[i+1] <= 1'b0;
      else if (adv) dv_v[i+1] <= dv_v[i];
    end

    always_ff @(posedge clk) begin
      if (adv) dv[i+1] <= dv[i];
    end
  end

  // stage h: saturated multiplier step
  xdc_side_t          h_side;
  logic               h_v;
  logic signed [31:0] h_dl;
  logic [NQ_W-1:0]    h_n [3];

  always_ff @(posedge clk) begin
    if (rst) h_v <= 1'b0;
    else if (adv) h_v <= dv_v[DV_N];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_side <= dv[DV_N].side;
      if (dv[DV_N].ovf) h_dl <= dv[DV_N].dneg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      else h_dl <= sat_mag(dv[DV_N].dneg, MAG_W'(dl_q[DV_N]));
      h_n[0] <= n_q[0][DV_N];
      h_n[1] <= n_q[1][DV_N];
      h_n[2] <= n_q[2][DV_N];
    end
  end

  // stage i: scaled direction s = dl*n and the new multiplier
  xdc_side_t          i_side;
  logic               i_v;
  logic [31:0]        i_smag [3];
  logic               i_sneg [3];
  logic signed [31:0] i_lam;
  logic [31:0]        dl_mag;
  logic [48:0]        sprod [3];
  logic signed [32:0] lam_sum;
  logic signed [31:0] lam_sat;

  always_comb begin
    dl_mag   = h_dl[31] ? 32'(-h_dl) : 32'(h_dl);
    sprod[0] = 49'(dl_mag) * 49'(h_n[0]);
    sprod[1] = 49'(dl_mag) * 49'(h_n[1]);
    sprod[2] = 49'(dl_mag) * 49'(h_n[2]);
    lam_sum  = {h_side.lam[31], h_side.lam} + {h_dl[31], h_dl};
    if (lam_sum[32] != lam_sum[31]) lam_sat = lam_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else lam_sat = lam_sum[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) i_v <= 1'b0;
    else if (adv) i_v <= h_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      i_side    <= h_side;
      i_smag[0] <= sprod[0][47:16];
      i_smag[1] <= sprod[1][47:16];
      i_smag[2] <= sprod[2][47:16];
      i_sneg[0] <= h_dl[31] ^ h_side.dx[32];
      i_sneg[1] <= h_dl[31] ^ h_side.dy[32];
      i_sneg[2] <= h_dl[31] ^ h_side.dz[32];
      i_lam     <= (compliance_on && !h_side.skip) ? lam_sat : h_side.lam;
    end
  end

  // stage j: weighted corrections
  xdc_side_t          j_side;
  logic               j_v;
  logic [46:0]        j_pi [3];
  logic [46:0]        j_pj [3];
  logic               j_sneg [3];
  logic signed [31:0] j_lam;
  logic [62:0]        wprod_i [3];
  logic [62:0]        wprod_j [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      wprod_i[k] = 63'(i_side.wi) * 63'(i_smag[k]);
      wprod_j[k] = 63'(i_side.wj) * 63'(i_smag[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) j_v <= 1'b0;
    else if (adv) j_v <= i_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_side <= i_side;
      j_lam  <= i_lam;
      for (int k = 0; k < 3; k++) begin
        j_pi[k]   <= wprod_i[k][62:16];
        j_pj[k]   <= wprod_j[k][62:16];
        j_sneg[k] <= i_sneg[k];
      end
    end
  end

  // output register with saturation and skip masking
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= j_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      edge_id_out <= j_side.eid;
      lambda_out  <= j_lam;
      skipped     <= j_side.skip;
      if (j_side.skip) begin
        corr_i_x <= '0;
        corr_i_y <= '0;
        corr_i_z <= '0;
        corr_j_x <= '0;
        corr_j_y <= '0;
        corr_j_z <= '0;
      end else begin
        corr_i_x <= sat_mag(j_sneg[0], MAG_W'(j_pi[0]));
        corr_i_y <= sat_mag(j_sneg[1], MAG_W'(j_pi[1]));
        corr_i_z <= sat_mag(j_sneg[2], MAG_W'(j_pi[2]));
        corr_j_x <= sat_mag(!j_sneg[0], MAG_W'(j_pj[0]));
        corr_j_y <= sat_mag(!j_sneg[1], MAG_W'(j_pj[1]));
        corr_j_z <= sat_mag(!j_sneg[2], MAG_W'(j_pj[2]));
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/xdc_port_checker.sv =====
// port-level checks of the distance constraint solver, bound to the top level
// depends on xpbd_distance_constraint_solve_macros.svh
`default_nettype none

`include "xpbd_distance_constraint_solve_macros.svh"

module xdc_port_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic signed [31:0] corr_i_x,
  input wire logic signed [31:0] corr_i_y,
  input wire logic signed [31:0] corr_i_z,
  input wire logic signed [31:0] corr_j_x,
  input wire logic signed [31:0] corr_j_y,
  input wire logic signed [31:0] corr_j_z,
  input wire logic signed [31:0] lambda_out,
  input wire logic               skipped
);

  // a stalled result stays put
  `XDC_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(lambda_out) && $stable(skipped))

  // a skipped edge carries no corrections
  `XDC_ASSERT_IMP(a_skip_zero, clk, rst, out_valid && skipped, corr_i_x == 0 && corr_i_y == 0 && corr_i_z == 0 && corr_j_x == 0 && corr_j_y == 0 && corr_j_z == 0)

  // input only stalls while the output is held
  `XDC_ASSERT_IMP(a_in_flow, clk, rst, !out_valid || !out_stall, !in_stall)

  // a held output stops the whole chain
  `XDC_ASSERT_IMP(a_in_block, clk, rst, out_valid && out_stall, in_stall)

endmodule

bind xpbd_distance_constraint_solve xdc_port_checker u_port_checker (.*);

`default_nettype wire
